>>> design/clrc_pkg.sv
package clrc_pkg;

  // Field widths
  localparam int unsigned SpeedW   = 15;
  localparam int unsigned DistW    = 15;
  localparam int unsigned GapW     = 13;
  localparam int unsigned FricW    = 11;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned SafeW    = 18;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Arithmetic widths
  localparam int unsigned SfW     = SpeedW + FricW;      // own speed times friction
  localparam int unsigned SsW     = 2 * SpeedW;          // own speed squared
  localparam int unsigned HkW     = 18;                  // reaction coefficient
  localparam int unsigned DenW    = 30;                  // divisor
  localparam int unsigned NumW    = 45;                  // dividend
  localparam int unsigned DivW    = DenW + SafeW;        // divider compare width
  localparam int unsigned MarginW = 15;                  // lane limits, 0.1 mm
  localparam int unsigned Gap10W  = GapW + 4;            // gap in 0.1 mm

  // Stopping distance over the common factor 800:
  //   (S*H*44145*F + 12800*S^2) / (317844*F), H in half seconds
  localparam int unsigned ReactK = 44145;
  localparam int unsigned DenK   = 317844;

  localparam logic [HkW-1:0] HkSporty = HkW'(2 * ReactK);
  localparam logic [HkW-1:0] HkNormal = HkW'(3 * ReactK);
  localparam logic [HkW-1:0] HkSafe   = HkW'(4 * ReactK);

  localparam logic [SafeW-1:0] SafeMax = '1;

  // Lane margin in 0.1 mm
  localparam logic [SpeedW-1:0]  LaneKnee = SpeedW'(8000);
  localparam logic [MarginW-1:0] LaneBase = MarginW'(5000);
  localparam logic [MarginW-1:0] LaneZone = MarginW'(2000);

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_FRICTION = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_MODE     = CfgIdxW'(1);

  localparam logic [FricW-1:0] FrictionRst = FricW'(717);

  // Sensitivity codes
  localparam logic [ModeW-1:0] MODE_SPORTY = ModeW'(0);
  localparam logic [ModeW-1:0] MODE_NORMAL = ModeW'(1);
  localparam logic [ModeW-1:0] MODE_SAFE   = ModeW'(2);

  typedef enum logic [StatW-1:0] {
    STAT_OK   = 2'd0,
    STAT_WARN = 2'd1,
    STAT_CRIT = 2'd2
  } status_e;

  typedef struct packed {
    logic [SpeedW-1:0] own_speed;
    logic [SpeedW-1:0] lead_speed;
    logic [DistW-1:0]  radar_distance;
    logic [DistW-1:0]  lidar_distance;
    logic [DistW-1:0]  camera_distance;
    logic [GapW-1:0]   left_lane_gap;
    logic [GapW-1:0]   right_lane_gap;
    logic              end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] fused_distance;
    logic [SafeW-1:0] safe_distance;
    logic [StatW-1:0] frontal_status;
    logic [StatW-1:0] left_status;
    logic [StatW-1:0] right_status;
    logic [StatW-1:0] overall_status;
    logic             batch_last;
  } out_item_t;

  // Per-item results that ride alongside the division
  typedef struct packed {
    logic [DistW-1:0] fused;
    logic             not_closing;
    logic             s_zero;
    status_e          left_st;
    status_e          right_st;
    logic             last;
  } side_t;

  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [SafeW-1:0] quo;
    logic             sat;
    side_t            side;
  } pipe_t;

endpackage

>>> design/clrc_if.sv
interface clrc_in_if;
  import clrc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clrc_out_if;
  import clrc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clrc_cfg_if;
  import clrc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> design/clrc_prep.sv
module clrc_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  clrc_pkg::in_item_t            item_i,
  input  logic [clrc_pkg::FricW-1:0]    friction_i,
  input  logic [clrc_pkg::ModeW-1:0]    mode_i,
  output logic                          valid_o,
  output clrc_pkg::pipe_t               pipe_o
);
  import clrc_pkg::*;

  function automatic status_e lane_grade(input logic [GapW-1:0] gap,
                                         input logic [MarginW-1:0] margin,
                                         input logic [MarginW-1:0] limit);
    logic [Gap10W-1:0] gap10;
    gap10 = (Gap10W'(gap) << 3) + (Gap10W'(gap) << 1);
    if (gap10 < Gap10W'(margin)) begin
      return STAT_CRIT;
    end else if (gap10 < Gap10W'(limit)) begin
      return STAT_WARN;
    end
    return STAT_OK;
  endfunction

  // Stage A: median, lane grading, first products
  logic [DistW-1:0]   lo_ab, hi_ab, mid_c;
  logic [MarginW-1:0] margin, limit;
  logic [HkW-1:0]     hk_d;
  side_t              side_d;

  always_comb begin
    lo_ab = (item_i.radar_distance < item_i.lidar_distance) ?
            item_i.radar_distance : item_i.lidar_distance;
    hi_ab = (item_i.radar_distance < item_i.lidar_distance) ?
            item_i.lidar_distance : item_i.radar_distance;
    mid_c = (hi_ab < item_i.camera_distance) ? hi_ab : item_i.camera_distance;

    margin = LaneBase;
    if (item_i.own_speed > LaneKnee) begin
      margin = LaneBase + MarginW'(item_i.own_speed - LaneKnee);
    end
    limit = margin + LaneZone;

    side_d.fused       = (lo_ab < mid_c) ? mid_c : lo_ab;
    side_d.not_closing = item_i.own_speed <= item_i.lead_speed;
    side_d.s_zero      = item_i.own_speed == '0;
    side_d.left_st     = lane_grade(item_i.left_lane_gap, margin, limit);
    side_d.right_st    = lane_grade(item_i.right_lane_gap, margin, limit);
    side_d.last        = item_i.end_of_batch;

    case (mode_i)
      MODE_SPORTY: hk_d = HkSporty;
      MODE_NORMAL: hk_d = HkNormal;
      MODE_SAFE:   hk_d = HkSafe;
      default:     hk_d = HkSafe;
    endcase
  end

  logic [SfW-1:0]  sf_q;
  logic [SsW-1:0]  ss_q;
  logic [HkW-1:0]  hk_q;
  logic [DenW-1:0] den_a_q, den_b_q, den_c_q;
  side_t           side_a_q, side_b_q, side_c_q;
  logic [NumW-1:0] p1_q, p2_q, n_q;
  logic            va_q, vb_q, vc_q, vd_q;
  pipe_t           pipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // Stage A
      sf_q     <= SfW'(item_i.own_speed) * SfW'(friction_i);
      ss_q     <= SsW'(item_i.own_speed) * SsW'(item_i.own_speed);
      hk_q     <= hk_d;
      den_a_q  <= DenW'(DenK) * DenW'(friction_i);
      side_a_q <= side_d;
      // Stage B: reaction term and braking term (times 12800)
      p1_q     <= NumW'(sf_q) * NumW'(hk_q);
      p2_q     <= (NumW'(ss_q) << 13) + (NumW'(ss_q) << 12) + (NumW'(ss_q) << 9);
      den_b_q  <= den_a_q;
      side_b_q <= side_a_q;
      // Stage C: dividend
      n_q      <= p1_q + p2_q;
      den_c_q  <= den_b_q;
      side_c_q <= side_b_q;
      // Stage D: saturation check, seed the divider
      pipe_q.rem  <= n_q;
      pipe_q.den  <= den_c_q;
      pipe_q.quo  <= '0;
      pipe_q.sat  <= DivW'(n_q) >= (DivW'(den_c_q) << SafeW);
      pipe_q.side <= side_c_q;
    end
  end

  assign valid_o = vd_q;
  assign pipe_o  = pipe_q;

endmodule

>>> design/clrc_div_step.sv
module clrc_div_step #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  clrc_pkg::pipe_t pipe_i,
  output logic            valid_o,
  output clrc_pkg::pipe_t pipe_o
);
  import clrc_pkg::*;

  logic [DivW-1:0] trial;
  pipe_t           pipe_d, pipe_q;
  logic            valid_q;

  // One restoring step: try the divisor at this bit position
  always_comb begin
    trial  = DivW'(pipe_i.den) << Bit;
    pipe_d = pipe_i;
    if (DivW'(pipe_i.rem) >= trial) begin
      pipe_d.rem      = pipe_i.rem - NumW'(trial);
      pipe_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

>>> design/clrc_grade.sv
module clrc_grade (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  clrc_pkg::pipe_t     pipe_i,
  output logic                valid_o,
  output clrc_pkg::out_item_t item_o
);
  import clrc_pkg::*;

  logic [SafeW-1:0] safe;
  logic [SafeW-1:0] fused_ext, fused_x2;
  status_e          front;
  logic [StatW-1:0] worst;
  out_item_t        item_d, item_q;
  logic             valid_q;

  always_comb begin
    if (pipe_i.side.s_zero) begin
      safe = '0;
    end else if (pipe_i.sat) begin
      safe = SafeMax;
    end else begin
      safe = pipe_i.quo;
    end

    fused_ext = SafeW'(pipe_i.side.fused);
    fused_x2  = fused_ext << 1;

    if (pipe_i.side.not_closing || fused_ext >= safe) begin
      front = STAT_OK;
    end else if (fused_x2 >= safe) begin
      front = STAT_WARN;
    end else begin
      front = STAT_CRIT;
    end

    worst = front;
    if (pipe_i.side.left_st > worst) begin
      worst = pipe_i.side.left_st;
    end
    if (pipe_i.side.right_st > worst) begin
      worst = pipe_i.side.right_st;
    end

    item_d.fused_distance = pipe_i.side.fused;
    item_d.safe_distance  = safe;
    item_d.frontal_status = front;
    item_d.left_status    = pipe_i.side.left_st;
    item_d.right_status   = pipe_i.side.right_st;
    item_d.overall_status = worst;
    item_d.batch_last     = pipe_i.side.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/collision_and_lane_risk_classifier_top.sv
// Each accepted input beat passes prep stages A to D, the divider and the output register to out_o.
// Throughput: one beat per cycle, sustained while out_o is ready; the 18-stage
// restoring divider (one quotient bit per stage) sets the pipeline depth.
// Reset: asynchronous, active low; clears every valid bit and loads friction
// 717 and sensitivity mode 1. No clearing pass is needed.
module collision_and_lane_risk_classifier_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  clrc_in_if.sink    in_i,
  clrc_out_if.source out_o,
  clrc_cfg_if.sink   cfg_i
);
  import clrc_pkg::*;

  // Configuration registers; the user must write them only while the pipeline is empty
  // (the block itself does not enforce this), so stage A reads them directly.
  logic [FricW-1:0] friction_q;
  logic [ModeW-1:0] mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      friction_q <= FrictionRst;
      mode_q     <= MODE_NORMAL;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FRICTION: friction_q <= cfg_i.wdata;
        REG_MODE:     mode_q     <= cfg_i.wdata[ModeW-1:0];
        default:      ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register is empty or
  // its beat is being taken. A stall holds every stage in place.
  logic adv;
  logic out_valid;

  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;

  // Front end: median, lane grading, products, dividend, saturation check
  logic  prep_valid;
  pipe_t prep_pipe;

  clrc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_i.valid),
    .item_i     (in_i.data),
    .friction_i (friction_q),
    .mode_i     (mode_q),
    .valid_o    (prep_valid),
    .pipe_o     (prep_pipe)
  );

  // Divider: one quotient bit per stage, most significant first
  logic  div_valid [SafeW+1];
  pipe_t div_pipe  [SafeW+1];

  assign div_valid[0] = prep_valid;
  assign div_pipe[0]  = prep_pipe;

  for (genvar g = 0; g < SafeW; g++) begin : g_div
    clrc_div_step #(
      .Bit (SafeW - 1 - g)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (div_valid[g]),
      .pipe_i  (div_pipe[g]),
      .valid_o (div_valid[g+1]),
      .pipe_o  (div_pipe[g+1])
    );
  end

  // Frontal grading, overall status and the output register
  clrc_grade u_grade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_valid[SafeW]),
    .pipe_i  (div_pipe[SafeW]),
    .valid_o (out_valid),
    .item_o  (out_o.data)
  );

  assign out_o.valid = out_valid;

endmodule
